// File: rtl/rie_pkg.sv
`timescale 1ns / 1ps

package rie_pkg;

  // instruction formats
  typedef enum logic [3:0] {
    FMT_R,
    FMT_LOAD,
    FMT_IA,
    FMT_SH,
    FMT_JALR,
    FMT_ECALL,
    FMT_S,
    FMT_B,
    FMT_U,
    FMT_J
  } fmt_e;

  // major opcodes
  localparam logic [6:0] OP_R      = 7'h33;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6F;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MUL  = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
  localparam logic [31:0] ERR_WORD   = 32'hFFFF_FFFF;

  localparam int unsigned ImmKeepW = 21;

  // mnemonic table entry
  typedef struct packed {
    logic       known;
    fmt_e       fmt;
    logic [6:0] opcode;
    logic [2:0] f3;
    logic [6:0] f7;
  } mnem_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                err;
    fmt_e                fmt;
    logic [6:0]          opcode;
    logic [2:0]          f3;
    logic [6:0]          f7;
    logic [4:0]          reg_a;
    logic [4:0]          reg_b;
    logic [4:0]          reg_c;
    logic [ImmKeepW-1:0] imm;
  } dec_t;

  function automatic mnem_t entry(input fmt_e fmt, input logic [6:0] opcode,
                                  input logic [2:0] f3, input logic [6:0] f7);
    mnem_t e;
    e.known  = 1'b1;
    e.fmt    = fmt;
    e.opcode = opcode;
    e.f3     = f3;
    e.f7     = f7;
    return e;
  endfunction

  // mnemonic code lookup, codes above the list are unknown
  function automatic mnem_t lookup(input logic [5:0] code);
    mnem_t m;
    m = '{known: 1'b0, fmt: FMT_R, opcode: OP_R, f3: 3'd0, f7: F7_BASE};
    case (code)
      6'd0:  m = entry(FMT_R, OP_R, 3'd0, F7_BASE);
      6'd1:  m = entry(FMT_R, OP_R, 3'd0, F7_MUL);
      6'd2:  m = entry(FMT_R, OP_R, 3'd0, F7_ALT);
      6'd3:  m = entry(FMT_R, OP_R, 3'd1, F7_BASE);
      6'd4:  m = entry(FMT_R, OP_R, 3'd1, F7_MUL);
      6'd5:  m = entry(FMT_R, OP_R, 3'd2, F7_BASE);
      6'd6:  m = entry(FMT_R, OP_R, 3'd3, F7_BASE);
      6'd7:  m = entry(FMT_R, OP_R, 3'd4, F7_BASE);
      6'd8:  m = entry(FMT_R, OP_R, 3'd4, F7_MUL);
      6'd9:  m = entry(FMT_R, OP_R, 3'd5, F7_BASE);
      6'd10: m = entry(FMT_R, OP_R, 3'd5, F7_ALT);
      6'd11: m = entry(FMT_R, OP_R, 3'd6, F7_BASE);
      6'd12: m = entry(FMT_R, OP_R, 3'd6, F7_MUL);
      6'd13: m = entry(FMT_R, OP_R, 3'd7, F7_BASE);
      6'd14: m = entry(FMT_LOAD, OP_LOAD, 3'd0, F7_BASE);
      6'd15: m = entry(FMT_LOAD, OP_LOAD, 3'd1, F7_BASE);
      6'd16: m = entry(FMT_LOAD, OP_LOAD, 3'd2, F7_BASE);
      6'd17: m = entry(FMT_LOAD, OP_LOAD, 3'd4, F7_BASE);
      6'd18: m = entry(FMT_LOAD, OP_LOAD, 3'd5, F7_BASE);
      6'd19: m = entry(FMT_IA, OP_IMM, 3'd0, F7_BASE);
      6'd20: m = entry(FMT_SH, OP_IMM, 3'd1, F7_BASE);
      6'd21: m = entry(FMT_IA, OP_IMM, 3'd2, F7_BASE);
      6'd22: m = entry(FMT_IA, OP_IMM, 3'd3, F7_BASE);
      6'd23: m = entry(FMT_IA, OP_IMM, 3'd4, F7_BASE);
      6'd24: m = entry(FMT_SH, OP_IMM, 3'd5, F7_BASE);
      6'd25: m = entry(FMT_SH, OP_IMM, 3'd5, F7_ALT);
      6'd26: m = entry(FMT_IA, OP_IMM, 3'd6, F7_BASE);
      6'd27: m = entry(FMT_IA, OP_IMM, 3'd7, F7_BASE);
      6'd28: m = entry(FMT_JALR, OP_JALR, 3'd0, F7_BASE);
      6'd29: m = entry(FMT_ECALL, OP_SYSTEM, 3'd0, F7_BASE);
      6'd30: m = entry(FMT_S, OP_STORE, 3'd0, F7_BASE);
      6'd31: m = entry(FMT_S, OP_STORE, 3'd1, F7_BASE);
      6'd32: m = entry(FMT_S, OP_STORE, 3'd2, F7_BASE);
      6'd33: m = entry(FMT_B, OP_BRANCH, 3'd0, F7_BASE);
      6'd34: m = entry(FMT_B, OP_BRANCH, 3'd1, F7_BASE);
      6'd35: m = entry(FMT_B, OP_BRANCH, 3'd4, F7_BASE);
      6'd36: m = entry(FMT_B, OP_BRANCH, 3'd5, F7_BASE);
      6'd37: m = entry(FMT_B, OP_BRANCH, 3'd6, F7_BASE);
      6'd38: m = entry(FMT_B, OP_BRANCH, 3'd7, F7_BASE);
      6'd39: m = entry(FMT_U, OP_AUIPC, 3'd0, F7_BASE);
      6'd40: m = entry(FMT_U, OP_LUI, 3'd0, F7_BASE);
      6'd41: m = entry(FMT_J, OP_JAL, 3'd0, F7_BASE);
      default: m.known = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/riscv_instruction_encoder_core.sv
`timescale 1ns / 1ps

// channel   | handshake        | payload
// ----------+------------------+------------------------------------------------
// request   | push / full      | req_type_i reg_a_i reg_b_i reg_c_i immediate_i
// result    | pop / empty      | machine_word_o encode_error_o
//
// one instruction per cycle sustained while pop keeps up; a request passes
// through the decode register, the queue and the output register.
// rst_ni clears the stage valids and the queue; no clearing pass is needed.
// a stalled pop backs up into the queue, then the decode stage, then full.
// errors give machine_word_o = 0xFFFFFFFF with encode_error_o set.

module riscv_instruction_encoder_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  req_type_i,
  input  logic [4:0]  reg_a_i,
  input  logic [4:0]  reg_b_i,
  input  logic [4:0]  reg_c_i,
  input  logic [31:0] immediate_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] machine_word_o,
  output logic        encode_error_o
);

  localparam int unsigned DecW = $bits(rie_pkg::dec_t);

  logic          fr_valid, fr_ready;
  rie_pkg::dec_t fr_dec;
  logic          bk_valid, bk_ready;
  logic [DecW-1:0] bk_bits;

  // decode and range check
  rie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .reg_a_i     (reg_a_i),
    .reg_b_i     (reg_b_i),
    .reg_c_i     (reg_c_i),
    .immediate_i (immediate_i),
    .dec_valid_o (fr_valid),
    .dec_ready_i (fr_ready),
    .dec_o       (fr_dec)
  );

  // decoupling queue between decode and packing
  rie_fifo #(
    .Depth (QueueDepth),
    .Width (DecW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_dec),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_bits)
  );

  // word packing and result register
  rie_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dec_valid_i    (bk_valid),
    .dec_ready_o    (bk_ready),
    .dec_i          (rie_pkg::dec_t'(bk_bits)),
    .empty          (empty),
    .pop            (pop),
    .machine_word_o (machine_word_o),
    .encode_error_o (encode_error_o)
  );

  // a valid encoding never has an all-ones word, so the flag follows the word
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (encode_error_o == (machine_word_o == rie_pkg::ERR_WORD)))
    else $error("error flag and error word disagree");

endmodule

// File: rtl/rie_front.sv
`timescale 1ns / 1ps

module rie_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [5:0]       req_type_i,
  input  logic [4:0]       reg_a_i,
  input  logic [4:0]       reg_b_i,
  input  logic [4:0]       reg_c_i,
  input  logic [31:0]      immediate_i,
  output logic             dec_valid_o,
  input  logic             dec_ready_i,
  output rie_pkg::dec_t    dec_o
);

  logic          valid_q, valid_d;
  rie_pkg::dec_t dec_q, dec_d;
  rie_pkg::mnem_t mnem;
  logic          range_ok;
  logic          take;

  // immediate range classes
  logic fits12, fits13, fits21, is_shamt, is_uimm;

  assign fits12   = (immediate_i[31:11] == '0) || (immediate_i[31:11] == '1);
  assign fits13   = (immediate_i[31:12] == '0) || (immediate_i[31:12] == '1);
  assign fits21   = (immediate_i[31:20] == '0) || (immediate_i[31:20] == '1);
  assign is_shamt = (immediate_i[31:5] == '0);
  assign is_uimm  = (immediate_i[31:20] == '0);

  // table lookup and range check per format
  always_comb begin
    mnem = rie_pkg::lookup(req_type_i);
    case (mnem.fmt)
      rie_pkg::FMT_R:     range_ok = 1'b1;
      rie_pkg::FMT_ECALL: range_ok = 1'b1;
      rie_pkg::FMT_LOAD:  range_ok = fits12;
      rie_pkg::FMT_IA:    range_ok = fits12;
      rie_pkg::FMT_JALR:  range_ok = fits12;
      rie_pkg::FMT_S:     range_ok = fits12;
      rie_pkg::FMT_SH:    range_ok = is_shamt;
      rie_pkg::FMT_B:     range_ok = fits13;
      rie_pkg::FMT_U:     range_ok = is_uimm;
      rie_pkg::FMT_J:     range_ok = fits21;
      default:            range_ok = 1'b0;
    endcase
    dec_d.err    = !(mnem.known && range_ok);
    dec_d.fmt    = mnem.fmt;
    dec_d.opcode = mnem.opcode;
    dec_d.f3     = mnem.f3;
    dec_d.f7     = mnem.f7;
    dec_d.reg_a  = reg_a_i;
    dec_d.reg_b  = reg_b_i;
    dec_d.reg_c  = reg_c_i;
    dec_d.imm    = immediate_i[rie_pkg::ImmKeepW-1:0];
  end

  // input transfer whenever the stage is empty or drains this cycle
  assign full = valid_q && !dec_ready_i;
  assign take = push && !full;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (dec_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = dec_q;

  // a stalled classified item holds until the queue takes it
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !dec_ready_i) |=> (valid_q && $stable(dec_q)))
    else $error("front stage lost or changed a stalled item");

endmodule

// File: rtl/rie_fifo.sv
`timescale 1ns / 1ps

module rie_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != FullCnt);
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue occupancy above depth");

  a_fifo_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) || (count_q == FullCnt)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with occupancy");

endmodule

// File: rtl/rie_back.sv
`timescale 1ns / 1ps

module rie_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          dec_valid_i,
  output logic          dec_ready_o,
  input  rie_pkg::dec_t dec_i,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   machine_word_o,
  output logic          encode_error_o
);

  logic          out_valid_q, out_valid_d;
  logic [31:0]   word_q, word_d;
  logic          err_q;
  logic          take;
  rie_pkg::dec_t d;

  assign d = dec_i;

  // field packing per format
  always_comb begin
    case (d.fmt)
      rie_pkg::FMT_R:
        word_d = {d.f7, d.reg_c, d.reg_b, d.f3, d.reg_a, d.opcode};
      rie_pkg::FMT_LOAD:
        word_d = {d.imm[11:0], d.reg_c, d.f3, d.reg_a, d.opcode};
      rie_pkg::FMT_IA, rie_pkg::FMT_JALR:
        word_d = {d.imm[11:0], d.reg_b, d.f3, d.reg_a, d.opcode};
      rie_pkg::FMT_SH:
        word_d = {d.f7, d.imm[4:0], d.reg_b, d.f3, d.reg_a, d.opcode};
      rie_pkg::FMT_ECALL:
        word_d = rie_pkg::ECALL_WORD;
      rie_pkg::FMT_S:
        word_d = {d.imm[11:5], d.reg_a, d.reg_c, d.f3, d.imm[4:0], d.opcode};
      rie_pkg::FMT_B:
        word_d = {d.imm[12], d.imm[10:5], d.reg_b, d.reg_a, d.f3,
                  d.imm[4:1], d.imm[11], d.opcode};
      rie_pkg::FMT_U:
        word_d = {d.imm[19:0], d.reg_a, d.opcode};
      rie_pkg::FMT_J:
        word_d = {d.imm[20], d.imm[10:1], d.imm[11], d.imm[19:12], d.reg_a, d.opcode};
      default:
        word_d = rie_pkg::ERR_WORD;
    endcase
    if (d.err) begin
      word_d = rie_pkg::ERR_WORD;
    end
  end

  // output register refills in the cycle its result is popped
  assign dec_ready_o = !out_valid_q || pop;
  assign take        = dec_valid_i && dec_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
      err_q  <= d.err;
    end
  end

  assign empty          = !out_valid_q;
  assign machine_word_o = word_q;
  assign encode_error_o = err_q;

  a_back_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(word_q)))
    else $error("result changed before it was popped");

endmodule
